/* rtl/core/mmlt_pkg.sv */
// Shared types and codes for the linked multimap table.
`timescale 1ns / 1ps
package mmlt_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_RSVD     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [15:0]        key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_value;
    logic [8:0]         total_count;
    logic               last;
  } rsp_t;

endpackage

/* rtl/core/multimap_linked_table.sv */
// Multimap of keys to value lists, kept as index-linked lists in RAMs.
// Each link walk passes a read state and then a compare state, as the RAM reads are registered;
// the final result strobe comes in the cycle after the last busy cycle, and OP_NONE answers
// without going busy. Search sends its values one by one, each through S_SRD and then S_SOUT,
// with last set on the final one; one request is taken at a time.
// After reset busy stays high while the key free chain is built; no stalls.
`timescale 1ns / 1ps
module multimap_linked_table
  import mmlt_pkg::*;
#(
  parameter int MAX_KEYS           = 16,
  parameter int MAX_VALUES_PER_KEY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output rsp_t rsp_o,
  output logic rsp_valid_o
);

  localparam int KA  = $clog2(MAX_KEYS);
  localparam int KW  = $clog2(MAX_KEYS + 1);
  localparam int VIA = $clog2(MAX_VALUES_PER_KEY);
  localparam int VW  = $clog2(MAX_VALUES_PER_KEY + 1);
  localparam int VD  = MAX_KEYS * MAX_VALUES_PER_KEY;
  localparam int VA  = $clog2(VD);
  localparam logic [KW-1:0] KNIL = KW'(MAX_KEYS);
  localparam logic [VW-1:0] VNIL = VW'(MAX_VALUES_PER_KEY);

  typedef enum logic [16:0] {
    S_INIT   = 17'h00001,
    S_IDLE   = 17'h00002,
    S_KRD    = 17'h00004,
    S_KCMP   = 17'h00008,
    S_ALLOC  = 17'h00010,
    S_LINKT  = 17'h00020,
    S_VINIT  = 17'h00040,
    S_VHRD   = 17'h00080,
    S_VH     = 17'h00100,
    S_ADDWR  = 17'h00200,
    S_VRD    = 17'h00400,
    S_VCMP   = 17'h00800,
    S_RM2    = 17'h01000,
    S_RM3    = 17'h02000,
    S_RM4    = 17'h04000,
    S_SRD    = 17'h08000,
    S_SOUT   = 17'h10000
  } state_e;

  state_e state_q, state_d;
  req_t req_q, req_d;
  logic [KW-1:0] cur_q, cur_d, prev_q, prev_d, steps_q, steps_d;
  logic [KW-1:0] khead_q, khead_d, kfh_q, kfh_d;
  logic [VA-1:0] base_q, base_d;
  logic [VW-1:0] vh_q, vh_d, vf_q, vf_d, vcur_q, vcur_d, vprev_q, vprev_d;
  logic [VW-1:0] vsteps_q, vsteps_d;
  logic [8:0] cnt_q, cnt_d;
  rsp_t rsp_q, rsp_d;
  logic valid_q, valid_d;

  // RAM ports
  logic ks_we, kl_we, vs_we, vl_we, vh_we, vf_we;
  logic [KA-1:0] ks_wa, ks_ra, kl_wa, kl_ra, vh_wa, vh_ra, vf_wa, vf_ra;
  logic [VA-1:0] vs_wa, vs_ra, vl_wa, vl_ra;
  logic [15:0] ks_wd, ks_rd;
  logic [KW-1:0] kl_wd, kl_rd;
  logic [31:0] vs_wd, vs_rd;
  logic [VW-1:0] vl_wd, vl_rd, vh_wd, vh_rd, vf_wd, vf_rd;

  logic [VA-1:0] va_cur, va_prev, va_free;
  logic [VA-1:0] base_new;
  logic          s_last;

  assign va_cur   = base_q + VA'(vcur_q[VIA-1:0]);
  assign va_prev  = base_q + VA'(vprev_q[VIA-1:0]);
  assign va_free  = base_q + VA'(vf_q[VIA-1:0]);
  assign base_new = VA'(cur_q[KA-1:0]) * VA'(MAX_VALUES_PER_KEY);
  assign s_last   = (vl_rd >= VNIL) || (VW'(vsteps_q + 1'b1) >= VNIL);

  mmlt_ram #(.WIDTH(16), .DEPTH(MAX_KEYS)) u_key_store (
    .clk_i, .we_i(ks_we), .waddr_i(ks_wa), .wdata_i(ks_wd), .raddr_i(ks_ra), .rdata_o(ks_rd));
  mmlt_ram #(.WIDTH(KW), .DEPTH(MAX_KEYS)) u_key_link (
    .clk_i, .we_i(kl_we), .waddr_i(kl_wa), .wdata_i(kl_wd), .raddr_i(kl_ra), .rdata_o(kl_rd));
  mmlt_ram #(.WIDTH(32), .DEPTH(VD)) u_value_store (
    .clk_i, .we_i(vs_we), .waddr_i(vs_wa), .wdata_i(vs_wd), .raddr_i(vs_ra), .rdata_o(vs_rd));
  mmlt_ram #(.WIDTH(VW), .DEPTH(VD)) u_value_link (
    .clk_i, .we_i(vl_we), .waddr_i(vl_wa), .wdata_i(vl_wd), .raddr_i(vl_ra), .rdata_o(vl_rd));
  mmlt_ram #(.WIDTH(VW), .DEPTH(MAX_KEYS)) u_value_head (
    .clk_i, .we_i(vh_we), .waddr_i(vh_wa), .wdata_i(vh_wd), .raddr_i(vh_ra), .rdata_o(vh_rd));
  mmlt_ram #(.WIDTH(VW), .DEPTH(MAX_KEYS)) u_value_free (
    .clk_i, .we_i(vf_we), .waddr_i(vf_wa), .wdata_i(vf_wd), .raddr_i(vf_ra), .rdata_o(vf_rd));

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    steps_d  = steps_q;
    khead_d  = khead_q;
    kfh_d    = kfh_q;
    base_d   = base_q;
    vh_d     = vh_q;
    vf_d     = vf_q;
    vcur_d   = vcur_q;
    vprev_d  = vprev_q;
    vsteps_d = vsteps_q;
    cnt_d    = cnt_q;
    rsp_d    = rsp_q;
    valid_d  = 1'b0;

    ks_we = 1'b0; ks_wa = cur_q[KA-1:0]; ks_wd = req_q.key; ks_ra = cur_q[KA-1:0];
    kl_we = 1'b0; kl_wa = cur_q[KA-1:0]; kl_wd = KNIL;      kl_ra = cur_q[KA-1:0];
    vs_we = 1'b0; vs_wa = va_free;       vs_wd = req_q.value; vs_ra = va_cur;
    vl_we = 1'b0; vl_wa = va_cur;        vl_wd = vh_q;      vl_ra = va_cur;
    vh_we = 1'b0; vh_wa = cur_q[KA-1:0]; vh_wd = VNIL;      vh_ra = cur_q[KA-1:0];
    vf_we = 1'b0; vf_wa = cur_q[KA-1:0]; vf_wd = '0;        vf_ra = cur_q[KA-1:0];

    unique case (state_q)
      S_INIT: begin
        // build the key free chain in index order
        kl_we = 1'b1;
        kl_wa = steps_q[KA-1:0];
        kl_wd = KW'(steps_q + 1'b1);
        steps_d = KW'(steps_q + 1'b1);
        if (steps_q == KW'(MAX_KEYS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          cur_d   = khead_q;
          prev_d  = KNIL;
          steps_d = '0;
          if (req_i.operation == OP_NONE) begin
            valid_d = 1'b1;
            rsp_d   = '{status: ST_NOTFOUND, found_value: '0, total_count: cnt_q, last: 1'b1};
          end else begin
            state_d = S_KRD;
          end
        end
      end
      S_KRD: begin
        if (cur_q >= KNIL || steps_q >= KNIL) begin
          if (req_q.operation == OP_ADD && kfh_q < KNIL) begin
            cur_d   = kfh_q;
            kl_ra   = kfh_q[KA-1:0];
            state_d = S_ALLOC;
          end else begin
            valid_d = 1'b1;
            rsp_d   = '{status: (req_q.operation == OP_ADD) ? ST_FULL : ST_NOTFOUND,
                        found_value: '0, total_count: cnt_q, last: 1'b1};
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_KCMP;
        end
      end
      S_KCMP: begin
        if (ks_rd == req_q.key) begin
          base_d  = base_new;
          state_d = S_VH;
        end else begin
          prev_d  = cur_q;
          cur_d   = kl_rd;
          steps_d = KW'(steps_q + 1'b1);
          state_d = S_KRD;
        end
      end
      S_ALLOC: begin
        kfh_d    = kl_rd;
        ks_we    = 1'b1;
        kl_we    = 1'b1;
        base_d   = base_new;
        vsteps_d = '0;
        if (prev_q < KNIL) begin
          state_d = S_LINKT;
        end else begin
          khead_d = cur_q;
          state_d = S_VINIT;
        end
      end
      S_LINKT: begin
        kl_we   = 1'b1;
        kl_wa   = prev_q[KA-1:0];
        kl_wd   = cur_q;
        state_d = S_VINIT;
      end
      S_VINIT: begin
        vl_we    = 1'b1;
        vl_wa    = base_q + VA'(vsteps_q[VIA-1:0]);
        vl_wd    = VW'(vsteps_q + 1'b1);
        vsteps_d = VW'(vsteps_q + 1'b1);
        if (vsteps_q == VW'(MAX_VALUES_PER_KEY - 1)) begin
          vh_we   = 1'b1;
          vf_we   = 1'b1;
          state_d = S_VHRD;
        end
      end
      S_VHRD: begin
        state_d = S_VH;
      end
      S_VH: begin
        vh_d     = vh_rd;
        vf_d     = vf_rd;
        vcur_d   = vh_rd;
        vprev_d  = VNIL;
        vsteps_d = '0;
        unique case (req_q.operation)
          OP_ADD: begin
            if (vf_rd >= VNIL) begin
              valid_d = 1'b1;
              rsp_d   = '{status: ST_FULL, found_value: '0, total_count: cnt_q, last: 1'b1};
              state_d = S_IDLE;
            end else begin
              vl_ra   = base_q + VA'(vf_rd[VIA-1:0]);
              state_d = S_ADDWR;
            end
          end
          OP_REMOVE: state_d = S_VRD;
          default:   state_d = S_SRD;
        endcase
      end
      S_ADDWR: begin
        // push the new value at the head of the key's list
        vs_we   = 1'b1;
        vl_we   = 1'b1;
        vl_wa   = va_free;
        vl_wd   = vh_q;
        vh_we   = 1'b1;
        vh_wd   = vf_q;
        vf_we   = 1'b1;
        vf_wd   = vl_rd;
        cnt_d   = cnt_q + 9'd1;
        valid_d = 1'b1;
        rsp_d   = '{status: ST_OK, found_value: '0, total_count: cnt_d, last: 1'b1};
        state_d = S_IDLE;
      end
      S_VRD: begin
        if (vcur_q >= VNIL || vsteps_q >= VNIL) begin
          valid_d = 1'b1;
          rsp_d   = '{status: ST_NOTFOUND, found_value: '0, total_count: cnt_q, last: 1'b1};
          state_d = S_IDLE;
        end else begin
          state_d = S_VCMP;
        end
      end
      S_VCMP: begin
        if (vs_rd == req_q.value) begin
          if (vprev_q < VNIL) begin
            vl_we = 1'b1;
            vl_wa = va_prev;
            vl_wd = vl_rd;
          end else begin
            vh_we = 1'b1;
            vh_wd = vl_rd;
            vh_d  = vl_rd;
          end
          state_d = S_RM2;
        end else begin
          vprev_d  = vcur_q;
          vcur_d   = vl_rd;
          vsteps_d = VW'(vsteps_q + 1'b1);
          state_d  = S_VRD;
        end
      end
      S_RM2: begin
        vl_we = 1'b1;
        vl_wd = vf_q;
        vf_we = 1'b1;
        vf_wd = vcur_q;
        if (vh_q >= VNIL) begin
          state_d = S_RM3;
        end else begin
          cnt_d   = cnt_q - 9'd1;
          valid_d = 1'b1;
          rsp_d   = '{status: ST_OK, found_value: '0, total_count: cnt_d, last: 1'b1};
          state_d = S_IDLE;
        end
      end
      S_RM3: begin
        // unlink the emptied key
        if (prev_q < KNIL) begin
          kl_we = 1'b1;
          kl_wa = prev_q[KA-1:0];
          kl_wd = kl_rd;
        end else begin
          khead_d = kl_rd;
        end
        state_d = S_RM4;
      end
      S_RM4: begin
        kl_we   = 1'b1;
        kl_wd   = kfh_q;
        kfh_d   = cur_q;
        cnt_d   = cnt_q - 9'd1;
        valid_d = 1'b1;
        rsp_d   = '{status: ST_OK, found_value: '0, total_count: cnt_d, last: 1'b1};
        state_d = S_IDLE;
      end
      S_SRD: begin
        if (vcur_q >= VNIL || vsteps_q >= VNIL) begin
          valid_d = 1'b1;
          rsp_d   = '{status: ST_NOTFOUND, found_value: '0, total_count: cnt_q, last: 1'b1};
          state_d = S_IDLE;
        end else begin
          state_d = S_SOUT;
        end
      end
      S_SOUT: begin
        valid_d  = 1'b1;
        rsp_d    = '{status: ST_OK, found_value: vs_rd, total_count: cnt_q, last: s_last};
        vcur_d   = vl_rd;
        vsteps_d = VW'(vsteps_q + 1'b1);
        state_d  = s_last ? S_IDLE : S_SRD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      steps_q  <= '0;
      khead_q  <= KNIL;
      kfh_q    <= '0;
      cnt_q    <= '0;
      valid_q  <= 1'b0;
      vsteps_q <= '0;
    end else begin
      state_q  <= state_d;
      steps_q  <= steps_d;
      khead_q  <= khead_d;
      kfh_q    <= kfh_d;
      cnt_q    <= cnt_d;
      valid_q  <= valid_d;
      vsteps_q <= vsteps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    base_q  <= base_d;
    vh_q    <= vh_d;
    vf_q    <= vf_d;
    vcur_q  <= vcur_d;
    vprev_q <= vprev_d;
    rsp_q   <= rsp_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_o       = rsp_q;
  assign rsp_valid_o = valid_q;

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.last |-> !busy) else $error("final result while busy");
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.last |-> busy) else $error("search ended early");
  a_full_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != ST_OK |-> rsp_o.last) else $error("error result not last");
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kfh_q <= KNIL) else $error("key free head out of range");

endmodule

/* rtl/core/mmlt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mmlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the linked multimap table, with a scoreboard class.
`timescale 1ns / 1ps
module tb_top;
  import mmlt_pkg::*;

  localparam int NKEYS = 16;
  localparam int NVALS = 16;
  localparam int KNIL  = NKEYS;
  localparam int VNIL  = NVALS;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  rsp_t rsp_o;
  logic rsp_valid_o;

  multimap_linked_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .rsp_o(rsp_o), .rsp_valid_o(rsp_valid_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  class table_scoreboard;
    logic [15:0] key_mem [NKEYS];
    int          key_nxt [NKEYS];
    int          key_head, key_free;
    logic [31:0] val_mem [NKEYS][NVALS];
    int          val_nxt [NKEYS][NVALS];
    int          val_head [NKEYS];
    int          val_free [NKEYS];
    int          pairs;
    rsp_t        pending[$];
    int          errors;

    function void clear();
      for (int i = 0; i < NKEYS; i++) begin
        key_nxt[i] = i + 1;
        val_head[i] = VNIL;
        val_free[i] = 0;
      end
      key_head = KNIL;
      key_free = 0;
      pairs = 0;
      errors = 0;
    endfunction

    function int lookup(logic [15:0] k, output int prev, output int tail);
      int cur, p, n;
      cur = key_head; p = KNIL; n = 0; tail = KNIL;
      while (cur < NKEYS && n < NKEYS) begin
        if (key_mem[cur] == k) begin
          prev = p;
          return cur;
        end
        tail = cur; p = cur; cur = key_nxt[cur]; n++;
      end
      prev = p;
      return KNIL;
    endfunction

    function void push(status_e st, logic [31:0] v, logic lst);
      rsp_t r;
      r.status = st; r.found_value = v; r.total_count = pairs[8:0]; r.last = lst;
      pending = {pending, r};
    endfunction

    function status_e insert(logic [15:0] k, logic [31:0] v);
      int prev, tail, ks, vs;
      ks = lookup(k, prev, tail);
      if (ks >= NKEYS) begin
        ks = key_free;
        if (ks >= NKEYS) return ST_FULL;
        key_free = key_nxt[ks];
        key_mem[ks] = k;
        key_nxt[ks] = KNIL;
        for (int i = 0; i < NVALS; i++) val_nxt[ks][i] = i + 1;
        val_head[ks] = VNIL;
        val_free[ks] = 0;
        if (tail < NKEYS) key_nxt[tail] = ks;
        else key_head = ks;
      end else if (val_free[ks] >= NVALS) begin
        return ST_FULL;
      end
      vs = val_free[ks];
      val_free[ks] = val_nxt[ks][vs];
      val_mem[ks][vs] = v;
      val_nxt[ks][vs] = val_head[ks];
      val_head[ks] = vs;
      pairs++;
      return ST_OK;
    endfunction

    function status_e unlink(logic [15:0] k, logic [31:0] v);
      int kp, tail, ks, cur, vp, n;
      ks = lookup(k, kp, tail);
      if (ks >= NKEYS) return ST_NOTFOUND;
      cur = val_head[ks]; vp = VNIL; n = 0;
      while (cur < NVALS && n < NVALS) begin
        if (val_mem[ks][cur] == v) break;
        vp = cur; cur = val_nxt[ks][cur]; n++;
      end
      if (cur >= NVALS || n >= NVALS) return ST_NOTFOUND;
      if (vp < NVALS) val_nxt[ks][vp] = val_nxt[ks][cur];
      else val_head[ks] = val_nxt[ks][cur];
      val_nxt[ks][cur] = val_free[ks];
      val_free[ks] = cur;
      if (val_head[ks] >= NVALS) begin
        if (kp < NKEYS) key_nxt[kp] = key_nxt[ks];
        else key_head = key_nxt[ks];
        key_nxt[ks] = key_free;
        key_free = ks;
      end
      pairs--;
      return ST_OK;
    endfunction

    function void note_request(req_t rq);
      int prev, tail, ks, cur, nx, n;
      case (rq.operation)
        OP_ADD: push(insert(rq.key, rq.value), '0, 1'b1);
        OP_REMOVE: push(unlink(rq.key, rq.value), '0, 1'b1);
        OP_SEARCH: begin
          ks = lookup(rq.key, prev, tail);
          n = 0;
          if (ks < NKEYS) begin
            cur = val_head[ks];
            while (cur < NVALS && n < NVALS) begin
              nx = val_nxt[ks][cur];
              push(ST_OK, val_mem[ks][cur], (nx >= NVALS || n + 1 >= NVALS));
              n++;
              cur = nx;
            end
          end
          if (n == 0) push(ST_NOTFOUND, '0, 1'b1);
        end
        default: push(ST_NOTFOUND, '0, 1'b1);
      endcase
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        errors++;
      end
      if (got.found_value !== exp_r.found_value) begin
        $display("%0t: found_value expected %0d actual %0d", $time,
                 exp_r.found_value, got.found_value);
        errors++;
      end
      if (got.total_count !== exp_r.total_count) begin
        $display("%0t: total_count expected %0d actual %0d", $time,
                 exp_r.total_count, got.total_count);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $display("%0t: last expected %0d actual %0d", $time, exp_r.last, got.last);
        errors++;
      end
    endfunction
  endclass

  table_scoreboard sb = new();
  logic [15:0] key_pool [8];
  bit          gaps_on = 1'b1;
  int          n_adds, n_removes, n_searches;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o) sb.check_result(rsp_o);
      if (start && !busy) sb.note_request(req_i);
    end
  end

  task automatic send(op_e op, logic [15:0] k, logic [31:0] v);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{operation: op, key: k, value: v};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    case (op)
      OP_ADD: n_adds++;
      OP_REMOVE: n_removes++;
      OP_SEARCH: n_searches++;
      default: ;
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return 32'($urandom_range(0, 7));
    endcase
  endfunction

  initial begin
    logic [15:0] k;
    int r;
    sb.clear();
    for (int i = 0; i < 8; i++) key_pool[i] = 16'($urandom);
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty table, extremes, unused code, fill one key's bank
    send(OP_SEARCH, 16'h0000, 32'h0);
    send(OP_REMOVE, 16'hFFFF, 32'h1);
    send(OP_NONE, 16'h1234, 32'h5);
    send(OP_ADD, 16'h0000, 32'h8000_0000);
    send(OP_ADD, 16'hFFFF, 32'h7FFF_FFFF);
    send(OP_REMOVE, 16'h0000, 32'h1);
    for (int i = 0; i < 16; i++) send(OP_ADD, 16'hFFFF, i);
    send(OP_SEARCH, 16'hFFFF, 32'hFFFF_FFFF);
    send(OP_REMOVE, 16'hFFFF, 32'd7);
    send(OP_SEARCH, 16'hFFFF, 32'h0);
    send(OP_REMOVE, 16'h0000, 32'h8000_0000);
    drain();

    // fill every key slot, then try one more key
    for (int i = 0; i < 16; i++) send(OP_ADD, 16'(16'h0100 + i), 32'hA5A5_0000 + i);
    send(OP_ADD, 16'hBEEF, 32'h0);
    for (int i = 15; i >= 0; i -= 3) send(OP_REMOVE, 16'(16'h0100 + i), 32'hA5A5_0000 + i);
    send(OP_ADD, 16'hBEEF, 32'h1);
    for (int i = 0; i < 16; i++) send(OP_SEARCH, 16'(16'h0100 + i), 32'h0);
    drain();

    // random traffic on a small key pool so lists grow and shrink
    for (int n = 0; n < 64; n++) begin
      if (n == 50) gaps_on = 1'b0;
      if (n == 30) drain();
      r = $urandom_range(0, 9);
      k = ($urandom_range(0, 15) == 0) ? 16'($urandom) : key_pool[$urandom_range(0, 7)];
      if (r < 5) send(OP_ADD, k, pick_value());
      else if (r < 8) send(OP_REMOVE, k, pick_value());
      else if (r < 9) send(OP_SEARCH, k, 32'($urandom));
      else send(op_e'($urandom_range(0, 3)), 16'($urandom), 32'($urandom));
    end
    drain();
    repeat (200) @(negedge clk_i);

    $display("Covered %0d adds, %0d removes, %0d searches, full and not-found paths.",
             n_adds, n_removes, n_searches);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
